### rtl/core/i2c_master_byte_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// I2C master byte sequencer assertion macros
// Shared property wrappers; clock is clk, reset is arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define I2CMBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cmbs assertion failed");

// next-cycle implication
`define I2CMBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cmbs assertion failed");

`endif

### rtl/core/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer package
// Request and result types, command codes and register constants.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

	localparam logic [15:0] DELAY_TICKS_RST = 16'd10;
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

	localparam logic [2:0] REQ_START    = 3'd0;
	localparam logic [2:0] REQ_STOP     = 3'd1;
	localparam logic [2:0] REQ_WRITE    = 3'd2;
	localparam logic [2:0] REQ_READ     = 3'd3;
	localparam logic [2:0] REQ_WAIT_ACK = 3'd4;
	localparam logic [2:0] REQ_SEND_ACK = 3'd5;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] req_type;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_error;
	} res_t;

endpackage

### rtl/core/i2c_master_byte_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Tick-driven bus sequencer for start, stop, byte write/read and ACK handling.
// ----------------------------------------------------------------------------
// Each request is one bus tick; one result per request. Throughput is one
// request per clock cycle while out_ready does not stall the result; a request
// passes the request register, the sequencer update and the result register.
// Commands are taken only while the sequencer is idle; others are ignored.
// Each bus delay lasts delay_ticks requests (zero counts as one). Registers:
// index 0 delay_ticks, index 1 ack_timeout; write only while idle.
module i2c_master_byte_sequencer_top
	import i2cmbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  req_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output res_t                  out_data
);

	typedef enum logic [15:0] {
		PH_IDLE    = 16'h0001,
		PH_ST_A    = 16'h0002,
		PH_ST_B    = 16'h0004,
		PH_SP_A    = 16'h0008,
		PH_SP_B    = 16'h0010,
		PH_SP_C    = 16'h0020,
		PH_WA_A    = 16'h0040,
		PH_WA_B    = 16'h0080,
		PH_WA_POLL = 16'h0100,
		PH_WB_A    = 16'h0200,
		PH_WB_B    = 16'h0400,
		PH_WB_C    = 16'h0800,
		PH_RB_A    = 16'h1000,
		PH_RB_B    = 16'h2000,
		PH_AK_A    = 16'h4000,
		PH_AK_B    = 16'h8000
	} phase_t;

	logic [15:0] delay_ticks_q;
	logic [7:0]  ack_timeout_q;

	phase_t      phase_q, phase_d;
	logic [15:0] dcnt_q, dcnt_d;
	logic [3:0]  bidx_q, bidx_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  poll_q, poll_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        dir_q, dir_d;
	logic [7:0]  rxb_q, rxb_d;
	logic        fail_q, fail_d;
	logic        ackc_q, ackc_d;
	logic        done_d;

	req_t        req_s1;
	logic        valid_s1;
	res_t        res_q;
	logic        out_valid_q;
	logic        advance;
	logic [15:0] dly_load;
	logic [3:0]  bidx_inc;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;
	assign dly_load  = (delay_ticks_q == 16'd0) ? 16'd1 : delay_ticks_q;
	assign bidx_inc  = bidx_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= DELAY_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY_TICKS: delay_ticks_q <= cfg_wdata;
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		dcnt_d  = dcnt_q;
		bidx_d  = bidx_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		dir_d   = dir_q;
		rxb_d   = rxb_q;
		fail_d  = fail_q;
		ackc_d  = ackc_q;
		done_d  = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (req_s1.cmd_valid) begin
				case (req_s1.req_type)
					REQ_START: begin
						dir_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
						dcnt_d = dly_load; phase_d = PH_ST_A;
					end
					REQ_STOP: begin
						dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
						dcnt_d = dly_load; phase_d = PH_SP_A;
					end
					REQ_WRITE: begin
						dir_d = 1'b1; scl_d = 1'b0; bidx_d = 4'd0;
						sda_d = req_s1.tx_byte[7];
						shift_d = {req_s1.tx_byte[6:0], 1'b0};
						dcnt_d = dly_load; phase_d = PH_WB_A;
					end
					REQ_READ: begin
						dir_d = 1'b0; scl_d = 1'b0; shift_d = 8'd0; bidx_d = 4'd0;
						ackc_d = req_s1.send_ack;
						dcnt_d = dly_load; phase_d = PH_RB_A;
					end
					REQ_WAIT_ACK: begin
						dir_d = 1'b0; sda_d = 1'b1; fail_d = 1'b0;
						dcnt_d = dly_load; phase_d = PH_WA_A;
					end
					REQ_SEND_ACK: begin
						ackc_d = req_s1.send_ack;
						scl_d = 1'b0; dir_d = 1'b1; sda_d = !req_s1.send_ack;
						dcnt_d = dly_load; phase_d = PH_AK_A;
					end
					default: ;
				endcase
			end
		end else if (phase_q == PH_WA_POLL) begin
			if (!req_s1.sda_in) begin
				scl_d = 1'b0; fail_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
			end else if (poll_q >= ack_timeout_q) begin
				fail_d = 1'b1;
				dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
				dcnt_d = dly_load; phase_d = PH_SP_A;
			end else begin
				poll_d = poll_q + 8'd1;
			end
		end else if (dcnt_q > 16'd1) begin
			dcnt_d = dcnt_q - 16'd1;
		end else begin
			dcnt_d = 16'd0;
			case (phase_q)
				PH_ST_A: begin sda_d = 1'b0; dcnt_d = dly_load; phase_d = PH_ST_B; end
				PH_ST_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
				PH_SP_A: begin scl_d = 1'b1; dcnt_d = dly_load; phase_d = PH_SP_B; end
				PH_SP_B: begin sda_d = 1'b1; dcnt_d = dly_load; phase_d = PH_SP_C; end
				PH_SP_C: begin phase_d = PH_IDLE; done_d = 1'b1; end
				PH_WA_A: begin scl_d = 1'b1; dcnt_d = dly_load; phase_d = PH_WA_B; end
				PH_WA_B: begin poll_d = 8'd0; phase_d = PH_WA_POLL; end
				PH_WB_A: begin scl_d = 1'b1; dcnt_d = dly_load; phase_d = PH_WB_B; end
				PH_WB_B: begin scl_d = 1'b0; dcnt_d = dly_load; phase_d = PH_WB_C; end
				PH_WB_C: begin
					bidx_d = bidx_inc;
					if (bidx_inc >= 4'd8) begin
						phase_d = PH_IDLE; done_d = 1'b1;
					end else begin
						sda_d = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						dcnt_d = dly_load; phase_d = PH_WB_A;
					end
				end
				PH_RB_A: begin
					scl_d = 1'b1;
					shift_d = {shift_q[6:0], req_s1.sda_in};
					dcnt_d = dly_load; phase_d = PH_RB_B;
				end
				PH_RB_B: begin
					bidx_d = bidx_inc;
					if (bidx_inc >= 4'd8) begin
						rxb_d = shift_q;
						scl_d = 1'b0; dir_d = 1'b1; sda_d = !ackc_q;
						dcnt_d = dly_load; phase_d = PH_AK_A;
					end else begin
						scl_d = 1'b0; dcnt_d = dly_load; phase_d = PH_RB_A;
					end
				end
				PH_AK_A: begin scl_d = 1'b1; dcnt_d = dly_load; phase_d = PH_AK_B; end
				PH_AK_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			dcnt_q      <= 16'd0;
			bidx_q      <= 4'd0;
			shift_q     <= 8'd0;
			poll_q      <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			dir_q       <= 1'b0;
			rxb_q       <= 8'd0;
			fail_q      <= 1'b0;
			ackc_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				dcnt_q      <= dcnt_d;
				bidx_q      <= bidx_d;
				shift_q     <= shift_d;
				poll_q      <= poll_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				dir_q       <= dir_d;
				rxb_q       <= rxb_d;
				fail_q      <= fail_d;
				ackc_q      <= ackc_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
		if (advance) begin
			res_q.scl_out   <= scl_d;
			res_q.sda_out   <= sda_d;
			res_q.sda_drive <= dir_d;
			res_q.busy_res  <= (phase_d != PH_IDLE);
			res_q.done_res  <= done_d;
			res_q.rx_byte   <= rxb_d;
			res_q.ack_error <= fail_d;
		end
	end

endmodule

### rtl/core/i2cmbs_checker.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_sequencer_top_assert.svh"

module i2cmbs_checker
	import i2cmbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input res_t out_data
);

	// stalled result holds
	`I2CMBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// a completion tick always leaves the sequencer idle
	`I2CMBS_ASSERT_NOW(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res)
	// empty result register never blocks requests
	`I2CMBS_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

endmodule

bind i2c_master_byte_sequencer_top i2cmbs_checker u_i2cmbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer testbench
// Drives bus ticks with random valid/ready gaps and a long output stall,
// predicts every result with an in-bench sequencer model and checks each
// field. Directed commands with reset and edge settings come first, then
// random well-formed transfers with some noise.
// ----------------------------------------------------------------------------
module testbench;
	import i2cmbs_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_START_SDA, S_START_SCL, S_STOP_SCL, S_STOP_SDA, S_STOP_END,
		S_ACKW_SCL, S_ACKW_SETTLE, S_ACKW_POLL, S_WR_RISE, S_WR_FALL, S_WR_NEXT,
		S_RD_RISE, S_RD_NEXT, S_AK_RISE, S_AK_FALL
	} seq_phase_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	req_t                  in_data;
	logic                  out_valid;
	logic                  out_ready;
	res_t                  out_data;

	// sequencer model state
	seq_phase_t  ph;
	logic [15:0] dly_cfg, dly_left;
	logic [7:0]  tmo_cfg, polls, shreg, rx_q;
	logic [3:0]  bit_no;
	logic        scl_q, sda_q, drv_q, fail_q, ack_pick;

	res_t pending_levels[$];
	res_t want;

	logic gaps_on;
	logic hold_req;
	int   noise_pct;
	int   fail_cnt;
	int   n_ticks;
	int   n_done;
	int   n_timeouts;
	int   n_checked;

	i2c_master_byte_sequencer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void arm(seq_phase_t nxt);
		dly_left = (dly_cfg == 16'd0) ? 16'd1 : dly_cfg;
		ph = nxt;
	endfunction

	function automatic void go_stop();
		drv_q = 1'b1;
		scl_q = 1'b0;
		sda_q = 1'b0;
		arm(S_STOP_SCL);
	endfunction

	function automatic void go_ack();
		scl_q = 1'b0;
		drv_q = 1'b1;
		sda_q = !ack_pick;
		arm(S_AK_RISE);
	endfunction

	function automatic void shift_out();
		sda_q = shreg[7];
		shreg = {shreg[6:0], 1'b0};
		arm(S_WR_RISE);
	endfunction

	// advances the model by one tick and returns the line levels, status and received byte it shows
	function automatic res_t bus_tick(req_t r);
		res_t o;
		logic done;
		done = 1'b0;
		if (ph == S_IDLE) begin
			if (r.cmd_valid) begin
				case (r.req_type)
					REQ_START: begin
						drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
						arm(S_START_SDA);
					end
					REQ_STOP: go_stop();
					REQ_WRITE: begin
						drv_q = 1'b1; scl_q = 1'b0;
						shreg = r.tx_byte; bit_no = '0;
						shift_out();
					end
					REQ_READ: begin
						drv_q = 1'b0; scl_q = 1'b0;
						shreg = '0; bit_no = '0;
						ack_pick = r.send_ack;
						arm(S_RD_RISE);
					end
					REQ_WAIT_ACK: begin
						drv_q = 1'b0; sda_q = 1'b1; fail_q = 1'b0;
						arm(S_ACKW_SCL);
					end
					REQ_SEND_ACK: begin
						ack_pick = r.send_ack;
						go_ack();
					end
					default: ;
				endcase
			end
		end else if (ph == S_ACKW_POLL) begin
			if (!r.sda_in) begin
				scl_q = 1'b0; fail_q = 1'b0;
				ph = S_IDLE; done = 1'b1;
			end else if (polls >= tmo_cfg) begin
				fail_q = 1'b1;
				n_timeouts++;
				go_stop();
			end else begin
				polls++;
			end
		end else if (dly_left > 16'd1) begin
			dly_left--;
		end else begin
			dly_left = '0;
			case (ph)
				S_START_SDA: begin sda_q = 1'b0; arm(S_START_SCL); end
				S_START_SCL: begin scl_q = 1'b0; ph = S_IDLE; done = 1'b1; end
				S_STOP_SCL: begin scl_q = 1'b1; arm(S_STOP_SDA); end
				S_STOP_SDA: begin sda_q = 1'b1; arm(S_STOP_END); end
				S_STOP_END: begin ph = S_IDLE; done = 1'b1; end
				S_ACKW_SCL: begin scl_q = 1'b1; arm(S_ACKW_SETTLE); end
				S_ACKW_SETTLE: begin polls = '0; ph = S_ACKW_POLL; end
				S_WR_RISE: begin scl_q = 1'b1; arm(S_WR_FALL); end
				S_WR_FALL: begin scl_q = 1'b0; arm(S_WR_NEXT); end
				S_WR_NEXT: begin
					bit_no++;
					if (bit_no >= 4'd8) begin
						ph = S_IDLE; done = 1'b1;
					end else begin
						shift_out();
					end
				end
				S_RD_RISE: begin
					scl_q = 1'b1;
					shreg = {shreg[6:0], r.sda_in};
					arm(S_RD_NEXT);
				end
				S_RD_NEXT: begin
					bit_no++;
					if (bit_no >= 4'd8) begin
						rx_q = shreg;
						go_ack();
					end else begin
						scl_q = 1'b0;
						arm(S_RD_RISE);
					end
				end
				S_AK_RISE: begin scl_q = 1'b1; arm(S_AK_FALL); end
				S_AK_FALL: begin scl_q = 1'b0; ph = S_IDLE; done = 1'b1; end
				default: ph = S_IDLE;
			endcase
		end
		if (done)
			n_done++;
		o.scl_out   = scl_q;
		o.sda_out   = sda_q;
		o.sda_drive = drv_q;
		o.busy_res  = (ph != S_IDLE);
		o.done_res  = done;
		o.rx_byte   = rx_q;
		o.ack_error = fail_q;
		return o;
	endfunction

	function automatic int idle_len();
		int p;
		if (!gaps_on)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic int ack_delay();
		if ($urandom_range(0, 3) == 0)
			return -1;
		return $urandom_range(0, tmo_cfg);
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	task automatic send_tick(input req_t r);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		pending_levels.push_back(bus_tick(r));
		n_ticks++;
	endtask

	// issues one command, then ticks until the sequencer is idle again;
	// ack_after is the number of high polls before SDA goes low, -1 never
	task automatic run_cmd(input logic [2:0] kind, input logic [7:0] data,
			input logic ack_bit, input logic [7:0] bus_byte, input int ack_after);
		req_t r;
		int   highs;
		highs       = 0;
		r.cmd_valid = 1'b1;
		r.req_type  = kind;
		r.tx_byte   = data;
		r.send_ack  = ack_bit;
		r.sda_in    = 1'($urandom_range(0, 1));
		send_tick(r);
		while (ph != S_IDLE) begin
			r.cmd_valid = ($urandom_range(0, 99) < noise_pct);
			r.req_type  = 3'($urandom_range(0, 7));
			r.tx_byte   = 8'($urandom_range(0, 255));
			r.send_ack  = 1'($urandom_range(0, 1));
			if (ph == S_ACKW_POLL)
				r.sda_in = (ack_after < 0 || highs < ack_after);
			else if (ph == S_RD_RISE)
				r.sda_in = bus_byte[7 - bit_no];
			else
				r.sda_in = 1'($urandom_range(0, 1));
			if (ph == S_ACKW_POLL && r.sda_in)
				highs++;
			send_tick(r);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [15:0] dly, input logic [7:0] tmo);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DELAY_TICKS;
		cfg_wdata <= dly;
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_wdata <= {junk, tmo};
		@(posedge clk);
		cfg_we  <= 1'b0;
		dly_cfg = dly;
		tmo_cfg = tmo;
	endtask

	task automatic test_reset_defaults();
		req_t r;
		run_cmd(REQ_START, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(REQ_WRITE, 8'hA5, 1'b0, 8'h00, 0);
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, 3);
		run_cmd(REQ_READ, 8'h00, 1'b1, 8'h5A, 0);
		run_cmd(REQ_SEND_ACK, 8'h00, 1'b0, 8'h00, 0);
		// no acknowledge: times out and runs the stop sequence
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, -1);
		run_cmd(3'd6, 8'hFF, 1'b1, 8'h00, 0);
		run_cmd(3'd7, 8'hFF, 1'b1, 8'h00, 0);
		r = '0;
		repeat (3) begin
			r.req_type = 3'($urandom_range(0, 7));
			r.sda_in   = 1'($urandom_range(0, 1));
			send_tick(r);
		end
		run_cmd(REQ_STOP, 8'h00, 1'b0, 8'h00, 0);
	endtask

	task automatic test_edge_values();
		reconfigure(16'd0, 8'd0);
		run_cmd(REQ_WRITE, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(REQ_WRITE, 8'hFF, 1'b1, 8'h00, 0);
		run_cmd(REQ_READ, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(REQ_READ, 8'hFF, 1'b1, 8'hFF, 0);
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, -1);
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(REQ_SEND_ACK, 8'h00, 1'b1, 8'h00, 0);
		run_cmd(REQ_SEND_ACK, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(REQ_START, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(REQ_STOP, 8'h00, 1'b0, 8'h00, 0);
		// commands offered while busy must be dropped
		noise_pct = 60;
		run_cmd(REQ_WRITE, 8'h3C, 1'b0, 8'h00, 0);
		run_cmd(REQ_READ, 8'h00, 1'b1, 8'hC3, 0);
		noise_pct = 0;
		reconfigure(16'd1, 8'd255);
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, -1);
		reconfigure(16'd3, 8'd1);
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, 1);
		run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, 2);
	endtask

	task automatic test_long_delay();
		gaps_on = 1'b0;
		reconfigure(16'd64, 8'd1);
		run_cmd(REQ_START, 8'h00, 1'b0, 8'h00, 0);
		reconfigure(16'd1, 8'd4);
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		reconfigure(16'd2, 8'd4);
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		run_cmd(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 0);
		run_cmd(REQ_READ, 8'h00, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0);
		run_cmd(REQ_STOP, 8'h00, 1'b0, 8'h00, 0);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int   stop_at;
		int   seq_no;
		int   p;
		req_t r;
		stop_at   = n_ticks + 300;
		seq_no    = 0;
		noise_pct = 8;
		while (n_ticks < stop_at) begin
			if (seq_no % 3 == 0) begin
				p = $urandom_range(0, 9);
				reconfigure((p < 2) ? 16'd0 : (p < 7) ? 16'd1 : 16'($urandom_range(2, 4)),
					($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 6)));
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 8) begin
				run_cmd(REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					8'h00, 0);
				run_cmd(REQ_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					8'h00, 0);
				run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, ack_delay());
				if (!fail_q) begin
					repeat ($urandom_range(1, 3)) begin
						if ($urandom_range(0, 1)) begin
							run_cmd(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 0);
							run_cmd(REQ_WAIT_ACK, 8'h00, 1'b0, 8'h00, ack_delay());
						end else begin
							run_cmd(REQ_READ, 8'($urandom_range(0, 255)),
								1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0);
						end
					end
					run_cmd(REQ_STOP, 8'h00, 1'b0, 8'h00, 0);
				end
			end else begin
				r = '0;
				repeat ($urandom_range(0, 3)) begin
					r.req_type = 3'($urandom_range(0, 7));
					r.tx_byte  = 8'($urandom_range(0, 255));
					r.send_ack = 1'($urandom_range(0, 1));
					r.sda_in   = 1'($urandom_range(0, 1));
					send_tick(r);
				end
				run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), ack_delay());
			end
			seq_no++;
		end
		noise_pct = 0;
	endtask

	// output side: random stalls, plus one long hold when requested
	initial begin
		int len;
		out_ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				len = idle_len();
				if (len > 0) begin
					out_ready <= 1'b0;
					repeat (len) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				$error("result arrived with no request outstanding");
				fail_cnt++;
			end else begin
				want = pending_levels.pop_front();
				check_field("scl_out", 8'(want.scl_out), 8'(out_data.scl_out));
				check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
				check_field("sda_drive", 8'(want.sda_drive), 8'(out_data.sda_drive));
				check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
				check_field("rx_byte", want.rx_byte, out_data.rx_byte);
				check_field("ack_error", 8'(want.ack_error), 8'(out_data.ack_error));
				n_checked++;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		gaps_on    = 1'b1;
		hold_req   = 1'b0;
		noise_pct  = 0;
		fail_cnt   = 0;
		n_ticks    = 0;
		n_done     = 0;
		n_timeouts = 0;
		n_checked  = 0;
		ph       = S_IDLE;
		dly_cfg  = DELAY_TICKS_RST;
		tmo_cfg  = ACK_TIMEOUT_RST;
		dly_left = '0;
		bit_no   = '0;
		shreg    = '0;
		polls    = '0;
		scl_q    = 1'b1;
		sda_q    = 1'b1;
		drv_q    = 1'b0;
		rx_q     = '0;
		fail_q   = 1'b0;
		ack_pick = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_edge_values();
		test_long_delay();
		test_backpressure();
		test_random_traffic();
		drain();

		$display("Covered %0d bus ticks: %0d commands completed, %0d acknowledge timeouts,",
			n_ticks, n_done, n_timeouts);
		$display("%0d results checked across reset, edge and random settings.", n_checked);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
